@@ rtl/xsbtc_pkg.sv @@
// Shared constants and types for the XOR below-threshold subarray counter.
// Holds key, pool and count sizes and the trie node word layout.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package xsbtc_pkg;

   // sizing of the trie and of the case
   localparam int KEY_BITS   = 32;
   localparam int MAX_ITEMS  = 1023;
   localparam int POOL_NODES = 32768;

   // fixed field widths
   localparam int VALUE_W = 32;
   localparam int THR_W   = 32;
   localparam int PAIRS_W = 11;
   localparam int TOTAL_W = 20;

   // derived widths
   localparam int LINK_W = $clog2(POOL_NODES + 1);
   localparam int ADDR_W = $clog2(POOL_NODES);
   localparam int CNT_W  = $clog2(MAX_ITEMS + 2);
   localparam int ITEM_W = $clog2(MAX_ITEMS + 1);
   localparam int LVL_W  = (KEY_BITS > 1) ? $clog2(KEY_BITS) : 1;

   // one trie node: two child links (zero means absent) and a pass count
   typedef struct packed {
      logic [LINK_W-1:0] link1;
      logic [LINK_W-1:0] link0;
      logic [CNT_W-1:0]  count;
   } node_type;

   localparam int NODE_W = $bits(node_type);

endpackage

`default_nettype wire

@@ rtl/xsbtc_ram.sv @@
// Generic simple dual-port RAM: one write port, one read port, registered read.
// Width and depth are parameters. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module xsbtc_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  wire                      clock,
   input  wire                      wr_en,
   input  wire [$clog2(DEPTH)-1:0]  wr_addr,
   input  wire [WIDTH-1:0]          wr_data,
   input  wire                      rd_en,
   input  wire [$clog2(DEPTH)-1:0]  rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   // write word
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // register read word
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule

`default_nettype wire

@@ rtl/xor_subarray_below_threshold_count_core.sv @@
// Steps per accepted word: a screen state, a query walk that stops where the compared path
// ends (skipped when the threshold reaches past the key bits), an insert walk and a hand-off
// state; a word that starts a case first rewrites the prefix-0 chain, a nearly full pool adds a probe walk.
// A new word is taken only once the last one has been handed off; the next word is taken
// while a result waits, but its own result is held until the waiting one is taken.
// Reset: synchronous; a pass writes the prefix-0 chain before the first word.
`timescale 1ns / 1ps
`default_nettype none

module xor_subarray_below_threshold_count_core (
   input  wire                                clock,
   input  wire                                reset,
   input  wire                                req_valid,
   output logic                               req_ready,
   input  wire [xsbtc_pkg::VALUE_W-1:0]       req_value,
   input  wire                                req_first_of_case,
   output logic                               rsp_valid,
   input  wire                                rsp_ready,
   output logic [xsbtc_pkg::PAIRS_W-1:0]      rsp_pairs_ending_here,
   output logic [xsbtc_pkg::TOTAL_W-1:0]      rsp_running_total,
   output logic                               rsp_overflow,
   input  wire                                csr_wr_en,
   input  wire [xsbtc_pkg::THR_W-1:0]         csr_wr_data
);

   localparam int KB = xsbtc_pkg::KEY_BITS;
   localparam int LW = xsbtc_pkg::LINK_W;
   localparam int AW = xsbtc_pkg::ADDR_W;
   localparam int CW = xsbtc_pkg::CNT_W;
   localparam int IW = xsbtc_pkg::ITEM_W;
   localparam int VW = xsbtc_pkg::LVL_W;

   typedef enum logic [6:0] {
      ST_INIT   = 7'b0000001,
      ST_IDLE   = 7'b0000010,
      ST_CHECK  = 7'b0000100,
      ST_PROBE  = 7'b0001000,
      ST_QUERY  = 7'b0010000,
      ST_INSERT = 7'b0100000,
      ST_FINISH = 7'b1000000
   } state_type;

   state_type state_ff, state_in;

   // control registers
   logic                           pending_ff, pending_in;
   logic [VW-1:0]                  lvl_ff, lvl_in;
   logic                           leaf_ff, leaf_in;
   logic                           at_root_ff, at_root_in;
   logic                           fresh_ff, fresh_in;
   logic                           via_other_ff, via_other_in;
   logic                           ovf_ff, ovf_in;
   logic                           rsp_valid_ff, rsp_valid_in;

   // case state
   logic [xsbtc_pkg::THR_W-1:0]    threshold_ff, threshold_in;
   logic [KB-1:0]                  prefix_ff, prefix_in;
   logic [xsbtc_pkg::TOTAL_W-1:0]  total_ff, total_in;
   logic [IW-1:0]                  items_ff, items_in;
   logic [LW-1:0]                  next_free_ff, next_free_in;
   logic [LW-1:0]                  root0_ff, root0_in;
   logic [LW-1:0]                  root1_ff, root1_in;

   // per-word working registers
   logic [xsbtc_pkg::VALUE_W-1:0]  value_ff, value_in;
   logic [KB-1:0]                  key_ff, key_in;
   logic [AW-1:0]                  cur_addr_ff, cur_addr_in;
   logic [CW-1:0]                  parent_cnt_ff, parent_cnt_in;
   logic [CW-1:0]                  sum_ff, sum_in;
   logic [xsbtc_pkg::PAIRS_W-1:0]  rsp_pairs_ff, rsp_pairs_in;
   logic [xsbtc_pkg::TOTAL_W-1:0]  rsp_total_ff, rsp_total_in;
   logic                           rsp_ovf_ff, rsp_ovf_in;

   // node RAM ports
   logic                           ram_wr_en;
   logic [AW-1:0]                  ram_wr_addr;
   xsbtc_pkg::node_type            ram_wr_data;
   logic                           ram_rd_en;
   logic [AW-1:0]                  ram_rd_addr;
   logic [xsbtc_pkg::NODE_W-1:0]   ram_rd_word;

   // combinational views
   xsbtc_pkg::node_type            node_cur;
   xsbtc_pkg::node_type            node_upd;
   logic                           bit_p;
   logic                           bit_k;
   logic [LW-1:0]                  same_link;
   logic [LW-1:0]                  other_link;
   logic [LW-1:0]                  child;
   logic [CW-1:0]                  sum_base;
   logic [CW-1:0]                  root_cnt;
   logic                           thr_wide;
   logic                           pool_near_full;
   logic                           pool_short;
   logic                           rsp_free;

   xsbtc_ram #(
      .WIDTH (xsbtc_pkg::NODE_W),
      .DEPTH (xsbtc_pkg::POOL_NODES)
   ) u_node_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_word)
   );

   // select the node under the walk: root registers, a fresh node, or RAM data
   assign root_cnt = CW'(items_ff) + CW'(1);
   always_comb begin
      if (at_root_ff) begin
         node_cur.link0 = root0_ff;
         node_cur.link1 = root1_ff;
         node_cur.count = root_cnt;
      end else if (fresh_ff) begin
         node_cur = '0;
      end else begin
         node_cur = xsbtc_pkg::node_type'(ram_rd_word);
      end
   end

   assign bit_p      = key_ff[lvl_ff];
   assign bit_k      = threshold_ff[lvl_ff];
   assign same_link  = bit_p ? node_cur.link1 : node_cur.link0;
   assign other_link = bit_p ? node_cur.link0 : node_cur.link1;
   assign sum_base   = via_other_ff ? (sum_ff + parent_cnt_ff - node_cur.count) : sum_ff;
   assign thr_wide   = (((xsbtc_pkg::THR_W + 1)'(threshold_ff)) >> KB) != '0;
   assign pool_near_full = ((LW + 1)'(next_free_ff) + (LW + 1)'(KB))
                           > (LW + 1)'(xsbtc_pkg::POOL_NODES);
   assign pool_short = ((LW + 1)'(next_free_ff) + (LW + 1)'(lvl_ff) + (LW + 1)'(1))
                       > (LW + 1)'(xsbtc_pkg::POOL_NODES);
   assign rsp_free   = !rsp_valid_ff || rsp_ready;
   assign req_ready  = (state_ff == ST_IDLE);

   // insert view: child link, allocating a fresh node where it is absent
   always_comb begin
      child = same_link;
      if (same_link == '0) begin
         child = next_free_ff + LW'(1);
      end
      node_upd = node_cur;
      node_upd.count = node_cur.count + CW'(1);
      if (!leaf_ff) begin
         if (bit_p) begin
            node_upd.link1 = child;
         end else begin
            node_upd.link0 = child;
         end
      end
   end

   // sequencer
   always_comb begin
      state_in      = state_ff;
      pending_in    = pending_ff;
      lvl_in        = lvl_ff;
      leaf_in       = leaf_ff;
      at_root_in    = at_root_ff;
      fresh_in      = fresh_ff;
      via_other_in  = via_other_ff;
      ovf_in        = ovf_ff;
      threshold_in  = threshold_ff;
      prefix_in     = prefix_ff;
      total_in      = total_ff;
      items_in      = items_ff;
      next_free_in  = next_free_ff;
      root0_in      = root0_ff;
      root1_in      = root1_ff;
      value_in      = value_ff;
      key_in        = key_ff;
      cur_addr_in   = cur_addr_ff;
      parent_cnt_in = parent_cnt_ff;
      sum_in        = sum_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_pairs_in  = rsp_pairs_ff;
      rsp_total_in  = rsp_total_ff;
      rsp_ovf_in    = rsp_ovf_ff;
      ram_wr_en     = 1'b0;
      ram_wr_addr   = cur_addr_ff;
      ram_wr_data   = node_upd;
      ram_rd_en     = 1'b0;
      ram_rd_addr   = AW'(same_link - LW'(1));

      // take threshold writes
      if (csr_wr_en) begin
         threshold_in = csr_wr_data;
      end

      unique case (state_ff)
         // write the prefix-0 chain, one node a cycle
         ST_INIT: begin
            ram_wr_en         = 1'b1;
            ram_wr_addr       = AW'(lvl_ff);
            ram_wr_data.link1 = '0;
            ram_wr_data.link0 = (lvl_ff == VW'(KB - 1)) ? '0 : (LW'(lvl_ff) + LW'(2));
            ram_wr_data.count = CW'(1);
            if (lvl_ff == VW'(KB - 1)) begin
               root0_in     = LW'(1);
               root1_in     = '0;
               next_free_in = LW'(KB);
               prefix_in    = '0;
               total_in     = '0;
               items_in     = '0;
               pending_in   = 1'b0;
               state_in     = pending_ff ? ST_CHECK : ST_IDLE;
            end else begin
               lvl_in = lvl_ff + VW'(1);
            end
         end

         // take a word
         ST_IDLE: begin
            if (req_valid) begin
               value_in = req_value;
               lvl_in   = '0;
               if (req_first_of_case) begin
                  pending_in = 1'b1;
                  state_in   = ST_INIT;
               end else begin
                  state_in = ST_CHECK;
               end
            end
         end

         // form the prefix and screen the limits
         ST_CHECK: begin
            key_in       = prefix_ff ^ value_ff[KB-1:0];
            lvl_in       = VW'(KB - 1);
            leaf_in      = 1'b0;
            at_root_in   = 1'b1;
            fresh_in     = 1'b0;
            via_other_in = 1'b0;
            sum_in       = '0;
            ovf_in       = 1'b0;
            if (items_ff >= IW'(xsbtc_pkg::MAX_ITEMS)) begin
               ovf_in   = 1'b1;
               state_in = ST_FINISH;
            end else if (pool_near_full) begin
               state_in = ST_PROBE;
            end else if (thr_wide) begin
               sum_in   = root_cnt;
               state_in = ST_INSERT;
            end else begin
               state_in = ST_QUERY;
            end
         end

         // walk the key path to count missing nodes
         ST_PROBE: begin
            if (leaf_ff || same_link == '0) begin
               lvl_in     = VW'(KB - 1);
               leaf_in    = 1'b0;
               at_root_in = 1'b1;
               if (!leaf_ff && pool_short) begin
                  ovf_in   = 1'b1;
                  state_in = ST_FINISH;
               end else if (thr_wide) begin
                  sum_in   = root_cnt;
                  state_in = ST_INSERT;
               end else begin
                  state_in = ST_QUERY;
               end
            end else begin
               ram_rd_en  = 1'b1;
               at_root_in = 1'b0;
               if (lvl_ff == '0) begin
                  leaf_in = 1'b1;
               end else begin
                  lvl_in = lvl_ff - VW'(1);
               end
            end
         end

         // count earlier prefixes below threshold, one level a cycle
         ST_QUERY: begin
            sum_in = sum_base;
            if (leaf_ff || (bit_k && other_link == '0) || (!bit_k && same_link == '0)) begin
               if (!leaf_ff && bit_k) begin
                  sum_in = sum_base + node_cur.count;
               end
               lvl_in       = VW'(KB - 1);
               leaf_in      = 1'b0;
               at_root_in   = 1'b1;
               fresh_in     = 1'b0;
               via_other_in = 1'b0;
               state_in     = ST_INSERT;
            end else begin
               ram_rd_en     = 1'b1;
               at_root_in    = 1'b0;
               via_other_in  = bit_k;
               parent_cnt_in = node_cur.count;
               if (bit_k) begin
                  ram_rd_addr = AW'(other_link - LW'(1));
               end
               if (lvl_ff == '0) begin
                  leaf_in = 1'b1;
               end else begin
                  lvl_in = lvl_ff - VW'(1);
               end
            end
         end

         // bump counts down the key path, linking fresh nodes where absent
         ST_INSERT: begin
            if (leaf_ff) begin
               ram_wr_en = 1'b1;
               prefix_in = key_ff;
               items_in  = items_ff + IW'(1);
               total_in  = total_ff + xsbtc_pkg::TOTAL_W'(sum_ff);
               state_in  = ST_FINISH;
            end else begin
               if (at_root_ff) begin
                  root0_in = node_upd.link0;
                  root1_in = node_upd.link1;
               end else begin
                  ram_wr_en = 1'b1;
               end
               if (same_link == '0) begin
                  next_free_in = next_free_ff + LW'(1);
                  fresh_in     = 1'b1;
               end else begin
                  ram_rd_en = !fresh_ff;
               end
               cur_addr_in = AW'(child - LW'(1));
               at_root_in  = 1'b0;
               if (lvl_ff == '0) begin
                  leaf_in = 1'b1;
               end else begin
                  lvl_in = lvl_ff - VW'(1);
               end
            end
         end

         // hand the result to the output register
         ST_FINISH: begin
            if (rsp_free) begin
               rsp_valid_in = 1'b1;
               rsp_pairs_in = ovf_ff ? '0 : xsbtc_pkg::PAIRS_W'(sum_ff);
               rsp_total_in = total_ff;
               rsp_ovf_in   = ovf_ff;
               state_in     = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_INIT;
            lvl_in   = '0;
         end
      endcase
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_INIT;
         pending_ff   <= 1'b0;
         lvl_ff       <= '0;
         leaf_ff      <= 1'b0;
         at_root_ff   <= 1'b1;
         fresh_ff     <= 1'b0;
         via_other_ff <= 1'b0;
         ovf_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
         threshold_ff <= '0;
         prefix_ff    <= '0;
         total_ff     <= '0;
         items_ff     <= '0;
         next_free_ff <= '0;
         root0_ff     <= '0;
         root1_ff     <= '0;
      end else begin
         state_ff     <= state_in;
         pending_ff   <= pending_in;
         lvl_ff       <= lvl_in;
         leaf_ff      <= leaf_in;
         at_root_ff   <= at_root_in;
         fresh_ff     <= fresh_in;
         via_other_ff <= via_other_in;
         ovf_ff       <= ovf_in;
         rsp_valid_ff <= rsp_valid_in;
         threshold_ff <= threshold_in;
         prefix_ff    <= prefix_in;
         total_ff     <= total_in;
         items_ff     <= items_in;
         next_free_ff <= next_free_in;
         root0_ff     <= root0_in;
         root1_ff     <= root1_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      value_ff      <= value_in;
      key_ff        <= key_in;
      cur_addr_ff   <= cur_addr_in;
      parent_cnt_ff <= parent_cnt_in;
      sum_ff        <= sum_in;
      rsp_pairs_ff  <= rsp_pairs_in;
      rsp_total_ff  <= rsp_total_in;
      rsp_ovf_ff    <= rsp_ovf_in;
   end

   assign rsp_valid             = rsp_valid_ff;
   assign rsp_pairs_ending_here = rsp_pairs_ff;
   assign rsp_running_total     = rsp_total_ff;
   assign rsp_overflow          = rsp_ovf_ff;

endmodule

`default_nettype wire

@@ tb/tb.sv @@
// Self-checking testbench for xor_subarray_below_threshold_count_core.
// Holds a trie-based predictor of the subarray counts and the stimulus tests.
// Depends on rtl/xsbtc_pkg.sv and rtl/xor_subarray_below_threshold_count_core.sv.
`timescale 1ns / 1ps

module tb;

   localparam int KEY_BITS   = xsbtc_pkg::KEY_BITS;
   localparam int MAX_ITEMS  = xsbtc_pkg::MAX_ITEMS;
   localparam int POOL_NODES = xsbtc_pkg::POOL_NODES;
   localparam int VALUE_W    = xsbtc_pkg::VALUE_W;
   localparam int THR_W      = xsbtc_pkg::THR_W;
   localparam int PAIRS_W    = xsbtc_pkg::PAIRS_W;
   localparam int TOTAL_W    = xsbtc_pkg::TOTAL_W;

   localparam int WATCHDOG_LIMIT = 5000;
   localparam logic [KEY_BITS-1:0] KEY_MASK = KEY_BITS'((64'd1 << KEY_BITS) - 64'd1);

   // one result word as the block should report it
   typedef struct packed {
      logic [PAIRS_W-1:0] pairs;
      logic [TOTAL_W-1:0] total;
      logic               overflow;
   } count_word_type;

   logic                 clock;
   logic                 reset;
   logic                 req_valid;
   logic                 req_ready;
   logic [VALUE_W-1:0]   req_value;
   logic                 req_first_of_case;
   logic                 rsp_valid;
   logic                 rsp_ready = 1'b0;
   logic [PAIRS_W-1:0]   rsp_pairs_ending_here;
   logic [TOTAL_W-1:0]   rsp_running_total;
   logic                 rsp_overflow;
   logic                 csr_wr_en;
   logic [THR_W-1:0]     csr_wr_data;

   xor_subarray_below_threshold_count_core dut (
      .clock                 (clock),
      .reset                 (reset),
      .req_valid             (req_valid),
      .req_ready             (req_ready),
      .req_value             (req_value),
      .req_first_of_case     (req_first_of_case),
      .rsp_valid             (rsp_valid),
      .rsp_ready             (rsp_ready),
      .rsp_pairs_ending_here (rsp_pairs_ending_here),
      .rsp_running_total     (rsp_running_total),
      .rsp_overflow          (rsp_overflow),
      .csr_wr_en             (csr_wr_en),
      .csr_wr_data           (csr_wr_data)
   );

   // predictor state: trie of earlier prefixes plus case bookkeeping
   int unsigned          trie_child0 [0:POOL_NODES];
   int unsigned          trie_child1 [0:POOL_NODES];
   int unsigned          trie_hits   [0:POOL_NODES];
   int unsigned          nodes_used;
   int unsigned          case_items;
   logic [KEY_BITS-1:0]  run_prefix;
   logic [TOTAL_W-1:0]   case_total;
   logic [THR_W-1:0]     thr_shadow;

   count_word_type       pending_counts[$];
   int                   mismatches = 0;
   bit                   steady_flow = 1'b0;
   int                   stall_left = 0;
   int                   idle_cycles = 0;

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // insert one prefix, allocating nodes along the way
   function automatic void trie_add(input logic [KEY_BITS-1:0] key);
      int unsigned cur;
      int unsigned nxt;
      cur = 0;
      for (int lvl = KEY_BITS - 1; lvl >= 0; lvl--) begin
         nxt = key[lvl] ? trie_child1[cur] : trie_child0[cur];
         if (nxt == 0) begin
            nodes_used++;
            nxt = nodes_used;
            trie_child0[nxt] = 0;
            trie_child1[nxt] = 0;
            trie_hits[nxt]   = 0;
            if (key[lvl]) trie_child1[cur] = nxt;
            else trie_child0[cur] = nxt;
         end
         cur = nxt;
         trie_hits[cur]++;
      end
   endfunction

   // nodes that inserting this prefix would allocate
   function automatic int unsigned fresh_nodes_for(input logic [KEY_BITS-1:0] key);
      int unsigned cur;
      int unsigned nxt;
      cur = 0;
      for (int lvl = KEY_BITS - 1; lvl >= 0; lvl--) begin
         nxt = key[lvl] ? trie_child1[cur] : trie_child0[cur];
         if (nxt == 0) return lvl + 1;
         cur = nxt;
      end
      return 0;
   endfunction

   // count stored prefixes whose XOR with key is below k
   function automatic int unsigned tally_below(input logic [KEY_BITS-1:0] key,
                                               input logic [THR_W-1:0] k);
      int unsigned cur;
      int unsigned same;
      int unsigned other;
      int unsigned tally;
      if ((64'(k) >> KEY_BITS) != 0) return case_items + 1;
      cur   = 0;
      tally = 0;
      for (int lvl = KEY_BITS - 1; lvl >= 0; lvl--) begin
         same  = key[lvl] ? trie_child1[cur] : trie_child0[cur];
         other = key[lvl] ? trie_child0[cur] : trie_child1[cur];
         if (k[lvl]) begin
            if (same != 0) tally += trie_hits[same];
            if (other == 0) break;
            cur = other;
         end else begin
            if (same == 0) break;
            cur = same;
         end
      end
      return tally;
   endfunction

   // empty the trie and put prefix 0 back
   function automatic void trie_start_case();
      trie_child0[0] = 0;
      trie_child1[0] = 0;
      trie_hits[0]   = 0;
      nodes_used     = 0;
      run_prefix     = '0;
      case_total     = '0;
      case_items     = 0;
      trie_add('0);
   endfunction

   // advance the predictor by one accepted word and return its result
   function automatic count_word_type count_and_insert_prefix(input logic [VALUE_W-1:0] value,
                                                              input logic starts_case);
      count_word_type      res;
      logic [KEY_BITS-1:0] p;
      int unsigned         cnt;
      if (starts_case) trie_start_case();
      p = (run_prefix ^ KEY_BITS'(value)) & KEY_MASK;
      if (case_items >= MAX_ITEMS || nodes_used + fresh_nodes_for(p) > POOL_NODES) begin
         res.pairs    = '0;
         res.total    = case_total;
         res.overflow = 1'b1;
         return res;
      end
      cnt = tally_below(p, thr_shadow);
      trie_add(p);
      run_prefix   = p;
      case_items++;
      case_total   = case_total + TOTAL_W'(cnt);
      res.pairs    = PAIRS_W'(cnt);
      res.total    = case_total;
      res.overflow = 1'b0;
      return res;
   endfunction

   // mostly short gaps, now and then a long one; none in steady flow
   function automatic int pick_gap();
      int r;
      if (steady_flow) return 0;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 85) return $urandom_range(1, 3);
      if (r < 96) return $urandom_range(4, 15);
      return $urandom_range(30, 120);
   endfunction

   // stall the result side at random
   always @(posedge clock) begin
      if (stall_left != 0) begin
         rsp_ready  <= 1'b0;
         stall_left <= stall_left - 1;
      end else begin
         rsp_ready <= 1'b1;
         if ($urandom_range(0, 15) == 0) stall_left <= pick_gap();
      end
   end

   // compare each accepted result word with the oldest expectation
   always @(posedge clock) begin
      count_word_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_counts.size() == 0) begin
            $error("result word with no expectation: pairs %0d total %0d overflow %0b",
                   rsp_pairs_ending_here, rsp_running_total, rsp_overflow);
            mismatches++;
         end else begin
            want = pending_counts.pop_front();
            if (rsp_pairs_ending_here !== want.pairs) begin
               $error("pairs_ending_here: expected %0d, got %0d",
                      want.pairs, rsp_pairs_ending_here);
               mismatches++;
            end
            if (rsp_running_total !== want.total) begin
               $error("running_total: expected %0d, got %0d", want.total, rsp_running_total);
               mismatches++;
            end
            if (rsp_overflow !== want.overflow) begin
               $error("overflow: expected %0b, got %0b", want.overflow, rsp_overflow);
               mismatches++;
            end
         end
      end
   end

   // end the run when nothing moves on either side for too long
   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("tb failed");
         $finish;
      end
   end

   // offer one word, hold it until accepted, then record its expected result
   task automatic send_word(input logic [VALUE_W-1:0] value, input logic starts_case);
      int gap;
      gap = pick_gap();
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid         <= 1'b1;
      req_value         <= value;
      req_first_of_case <= starts_case;
      do @(posedge clock); while (!req_ready);
      pending_counts.push_back(count_and_insert_prefix(value, starts_case));
   endtask

   // hold off the sender until every expected result has come back
   task automatic drain_counts();
      req_valid <= 1'b0;
      do @(posedge clock); while (pending_counts.size() != 0);
      repeat (4) @(posedge clock);
   endtask

   // write the threshold; only called with the block idle
   task automatic set_threshold(input logic [THR_W-1:0] thr);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= thr;
      @(posedge clock);
      csr_wr_en  <= 1'b0;
      thr_shadow = thr;
   endtask

   // value patterns: full random, small, single bit, near all-zero or all-one
   function automatic logic [VALUE_W-1:0] make_value(input int style);
      case (style)
         0: return $urandom;
         1: return $urandom_range(0, 15);
         2: return ($urandom_range(0, 4) == 0) ? '0 : (VALUE_W'(1) << $urandom_range(0, 31));
         default: return ($urandom_range(0, 1) ? {VALUE_W{1'b1}} : '0) ^ $urandom_range(0, 7);
      endcase
   endfunction

   // extremes of value and threshold, repeated prefixes and case restarts
   task automatic test_extremes();
      send_word(32'h0000_0000, 1'b0);
      send_word(32'hFFFF_FFFF, 1'b0);
      send_word(32'hFFFF_FFFF, 1'b0);
      drain_counts();
      set_threshold(32'h0000_0001);
      send_word(32'h0000_0000, 1'b0);
      send_word(32'h0000_0001, 1'b0);
      send_word(32'h0000_0001, 1'b0);
      drain_counts();
      set_threshold(32'hFFFF_FFFF);
      send_word(32'h8000_0000, 1'b0);
      send_word(32'h0000_0001, 1'b0);
      send_word(32'hFFFF_FFFF, 1'b1);
      send_word(32'hFFFF_FFFF, 1'b0);
      send_word(32'h0000_0000, 1'b0);
      drain_counts();
      set_threshold(32'h8000_0000);
      send_word(32'h7FFF_FFFF, 1'b1);
      send_word(32'h8000_0000, 1'b0);
      send_word(32'h5555_5555, 1'b0);
      send_word(32'hAAAA_AAAA, 1'b0);
      send_word(32'hFFFF_FFFF, 1'b0);
   endtask

   // random cases of mixed length and value pattern under one threshold
   task automatic run_random_phase(input logic [THR_W-1:0] thr, input int words,
                                   input bit no_gaps);
      int sent;
      int case_len;
      int style;
      drain_counts();
      set_threshold(thr);
      steady_flow = no_gaps;
      sent = 0;
      while (sent < words) begin
         case_len = ($urandom_range(0, 9) < 7) ? $urandom_range(1, 12) : $urandom_range(13, 60);
         style    = $urandom_range(0, 3);
         for (int i = 0; i < case_len && sent < words; i++) begin
            send_word(make_value(style), (i == 0) || ($urandom_range(0, 39) == 0));
            sent++;
         end
      end
      steady_flow = 1'b0;
   endtask

   task automatic test_random_cases();
      run_random_phase(32'h0000_0001, 30, 1'b0);
      run_random_phase($urandom, 30, 1'b0);
      run_random_phase(32'hFFFF_FFFF, 30, 1'b0);
      run_random_phase($urandom_range(1, 16), 30, 1'b1);
      run_random_phase(32'h8000_0000, 30, 1'b0);
      run_random_phase($urandom, 30, 1'b0);
      run_random_phase(32'h0000_0000, 30, 1'b0);
      run_random_phase(32'h7FFF_FFFF, 30, 1'b0);
   endtask

   // fill one case past the item limit, then restart and keep going
   task automatic test_item_limit();
      drain_counts();
      set_threshold(32'hFFFF_FFFF);
      for (int i = 0; i < MAX_ITEMS + 6; i++) begin
         send_word($urandom_range(0, 3), i == 0);
      end
      send_word($urandom, 1'b1);
      send_word($urandom, 1'b0);
   endtask

   initial begin
      reset             <= 1'b1;
      req_valid         <= 1'b0;
      req_value         <= '0;
      req_first_of_case <= 1'b0;
      csr_wr_en         <= 1'b0;
      csr_wr_data       <= '0;
      thr_shadow = '0;
      trie_start_case();
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      test_extremes();
      test_random_cases();
      test_item_limit();

      // let the last results land, then give the block time to settle
      drain_counts();
      repeat (150) @(posedge clock);
      if (mismatches == 0) begin
         $display("tb passed");
      end else begin
         $display("tb failed");
      end
      $finish;
   end

endmodule

@@ xor_subarray_below_threshold_count_core.f @@
rtl/xsbtc_pkg.sv
rtl/xsbtc_ram.sv
rtl/xor_subarray_below_threshold_count_core.sv
tb/tb.sv
